// File: rtl/core/nv21_to_argb_converter_defines.svh
// ---------------------------------------------------------------------------
// NV21 to ARGB converter assertion macros
// Shared assertion wrappers; defining ASSERT_OFF compiles them away.
// ---------------------------------------------------------------------------
`ifndef NV21_TO_ARGB_CONVERTER_DEFINES_SVH
`define NV21_TO_ARGB_CONVERTER_DEFINES_SVH

`ifndef ASSERT_OFF
`define N2A_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("n2a: implication check failed");
`define N2A_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("n2a: next-cycle check failed");
`else
`define N2A_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define N2A_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: rtl/core/n2a_pkg.sv
// ---------------------------------------------------------------------------
// NV21 to ARGB converter package
// Field widths, register codes, conversion weights and channel packing.
// ---------------------------------------------------------------------------
package n2a_pkg;

  localparam int BYTE_W        = 8;
  localparam int PIXEL_INDEX_W = 20;
  localparam int PIXEL_WORD_W  = 32;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 12;
  localparam int COORD_W       = 12;
  localparam int SIZE_W        = 24;
  localparam int TOTAL_W       = 25;
  localparam int IDX_W         = 25;
  localparam int CALC_W        = 21;

  localparam int RESET_FRAME_WIDTH  = 640;
  localparam int RESET_FRAME_HEIGHT = 480;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FRAME_WIDTH   = 2'd0,
    CFG_FRAME_HEIGHT  = 2'd1,
    CFG_OUTPUT_ENABLE = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    K_IGNORE,
    K_PAST,
    K_LUMA,
    K_CHROMA_V,
    K_END,
    K_BLOCK
  } byte_kind_t;

  localparam logic [BYTE_W-1:0] LUMA_OFFSET = 8'd16;
  localparam logic [BYTE_W-1:0] ALPHA       = 8'hff;

  localparam logic signed [CALC_W-1:0] C_Y  = 21'sd1192;
  localparam logic signed [CALC_W-1:0] C_RV = 21'sd1634;
  localparam logic signed [CALC_W-1:0] C_GV = -21'sd833;
  localparam logic signed [CALC_W-1:0] C_GU = -21'sd400;
  localparam logic signed [CALC_W-1:0] C_BU = 21'sd2066;
  localparam logic signed [CALC_W-1:0] CHAN_MAX = 21'sd262143;

  // Clamp a channel sum to 0..262143 and keep bits 17..10.
  function automatic logic [BYTE_W-1:0] chan_byte(input logic signed [CALC_W-1:0] x);
    logic [BYTE_W-1:0] b;
    if (x[CALC_W-1]) begin
      b = 8'h00;
    end else if (x > CHAN_MAX) begin
      b = 8'hff;
    end else begin
      b = x[17:10];
    end
    return b;
  endfunction

endpackage

// File: rtl/core/n2a_if.sv
// ---------------------------------------------------------------------------
// NV21 to ARGB converter channel interfaces
// Byte stream into the converter and pixel stream out of it.
// ---------------------------------------------------------------------------
interface n2a_byte_if;
  import n2a_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic              start_of_frame;

  modport source (output valid, output frame_byte, output start_of_frame, input ready);
  modport sink (input valid, input frame_byte, input start_of_frame, output ready);
endinterface

interface n2a_pixel_if;
  import n2a_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [PIXEL_INDEX_W-1:0] pixel_index;
  logic [PIXEL_WORD_W-1:0]  pixel_word;
  logic                     block_last;
  logic                     frame_last;

  modport source (output valid, output pixel_index, output pixel_word,
                  output block_last, output frame_last, input ready);
  modport sink (input valid, input pixel_index, input pixel_word,
                input block_last, input frame_last, output ready);
endinterface

// File: rtl/core/nv21_to_argb_converter.sv
// ---------------------------------------------------------------------------
// NV21 to ARGB converter
// Stores the luma plane of an NV21 frame and emits four ARGB pixels per
// chroma pair through a stallable read and arithmetic pipeline.
// ---------------------------------------------------------------------------
// Luma bytes and V bytes are taken at one per cycle, though a luma byte waits
// while a block job runs. A U byte loads a block job that issues four luma
// reads, one per cycle while the output is not stalled, through the single
// read port of the luma memory; the next U byte or luma byte is taken in the
// cycle the fourth read issues, and V bytes are taken while a job runs. Pixels
// therefore leave at one per cycle while the output is not stalled. The luma
// memory needs no clearing pass after reset. The output register holds a
// stalled item while the whole pipeline waits.
`include "nv21_to_argb_converter_defines.svh"

module nv21_to_argb_converter #(
  parameter int MAX_PIXELS = 1048576
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [n2a_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [n2a_pkg::CFG_DATA_W-1:0]   cfg_data,
  n2a_byte_if.sink                         frame,
  n2a_pixel_if.source                      pixel
);
  import n2a_pkg::*;

  localparam int ADDR_W = $clog2(MAX_PIXELS);
  localparam int POS_W  = $clog2(MAX_PIXELS + MAX_PIXELS / 2 + 1);
  localparam int RESET_SIZE = RESET_FRAME_WIDTH * RESET_FRAME_HEIGHT;
  localparam bit RESET_GEOM_OK = (RESET_SIZE <= MAX_PIXELS);

  // Configuration and derived geometry.
  logic [CFG_DATA_W-1:0] frame_width;
  logic [CFG_DATA_W-1:0] frame_height;
  logic                  output_enable;
  logic [POS_W-1:0]      frame_size;
  logic [POS_W-1:0]      frame_total;
  logic                  geom_ok;

  logic [CFG_DATA_W-1:0] width_next;
  logic [CFG_DATA_W-1:0] height_next;
  logic                  enable_next;
  logic [SIZE_W-1:0]     size_next;
  logic [TOTAL_W-1:0]    total_next;
  logic                  geom_next;

  always_comb begin
    width_next  = frame_width;
    height_next = frame_height;
    enable_next = output_enable;
    unique case (cfg_index)
      CFG_FRAME_WIDTH:   width_next  = cfg_data;
      CFG_FRAME_HEIGHT:  height_next = cfg_data;
      CFG_OUTPUT_ENABLE: enable_next = cfg_data[0];
      default: ;
    endcase
    size_next  = SIZE_W'(width_next) * SIZE_W'(height_next);
    total_next = TOTAL_W'(size_next) + TOTAL_W'(size_next >> 1);
    geom_next  = (width_next >= CFG_DATA_W'(2)) && (height_next >= CFG_DATA_W'(2)) &&
                 !width_next[0] && !height_next[0] &&
                 (size_next <= SIZE_W'(MAX_PIXELS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= CFG_DATA_W'(RESET_FRAME_WIDTH);
      frame_height  <= CFG_DATA_W'(RESET_FRAME_HEIGHT);
      output_enable <= 1'b1;
      frame_size    <= POS_W'(RESET_SIZE);
      frame_total   <= POS_W'(RESET_SIZE + RESET_SIZE / 2);
      geom_ok       <= RESET_GEOM_OK;
    end else if (cfg_write) begin
      frame_width   <= width_next;
      frame_height  <= height_next;
      output_enable <= enable_next;
      frame_size    <= POS_W'(size_next);
      frame_total   <= POS_W'(total_next);
      geom_ok       <= geom_next;
    end
  end

  logic [COORD_W-1:0] half_w;
  logic [COORD_W-1:0] half_h;
  assign half_w = {1'b0, frame_width[CFG_DATA_W-1:1]};
  assign half_h = {1'b0, frame_height[CFG_DATA_W-1:1]};

  // Frame position state.
  logic [POS_W-1:0]   byte_position;
  logic [COORD_W-1:0] chroma_column;
  logic [COORD_W-1:0] chroma_row;
  logic [BYTE_W-1:0]  held_v;

  // Block job and pipeline control.
  logic                    job_valid;
  logic [1:0]              job_k;
  logic [IDX_W-1:0]        job_base;
  logic                    job_last_block;
  logic signed [CALC_W-1:0] job_rv;
  logic signed [CALC_W-1:0] job_gv;
  logic signed [CALC_W-1:0] job_bu;
  logic                    adv;
  logic                    issue;
  logic                    job_done;
  logic                    out_valid;

  assign adv      = !out_valid || pixel.ready;
  assign issue    = job_valid && adv;
  assign job_done = issue && (job_k == 2'd3);

  // Input decode.
  logic [POS_W-1:0]   pos_eff;
  logic [COORD_W-1:0] col_eff;
  logic [COORD_W-1:0] row_eff;
  logic [COORD_W-1:0] blk_col;
  logic [COORD_W-1:0] blk_row;
  logic [COORD_W-1:0] col_inc;
  logic [SIZE_W-1:0]  row_prod;
  byte_kind_t         kind;
  logic               needs_slot;
  logic               accept;
  logic signed [CALC_W-1:0] v_s;
  logic signed [CALC_W-1:0] u_s;

  always_comb begin
    pos_eff = frame.start_of_frame ? '0 : byte_position;
    col_eff = frame.start_of_frame ? '0 : chroma_column;
    row_eff = frame.start_of_frame ? '0 : chroma_row;
    if (col_eff >= half_w) begin
      blk_col = '0;
      blk_row = row_eff + COORD_W'(1);
    end else begin
      blk_col = col_eff;
      blk_row = row_eff;
    end
    col_inc  = blk_col + COORD_W'(1);
    row_prod = SIZE_W'(blk_row) * SIZE_W'(frame_width);

    if (!output_enable || !geom_ok) begin
      kind = K_IGNORE;
    end else if (pos_eff >= frame_total) begin
      kind = K_PAST;
    end else if (pos_eff < frame_size) begin
      kind = K_LUMA;
    end else if (!pos_eff[0]) begin
      kind = K_CHROMA_V;
    end else if (blk_row >= half_h) begin
      kind = K_END;
    end else begin
      kind = K_BLOCK;
    end
    needs_slot = (kind == K_LUMA) || (kind == K_BLOCK);

    // Offset-binary chroma to two's complement by flipping the top bit.
    v_s = CALC_W'(signed'({~held_v[BYTE_W-1], held_v[BYTE_W-2:0]}));
    u_s = CALC_W'(signed'({~frame.frame_byte[BYTE_W-1], frame.frame_byte[BYTE_W-2:0]}));
  end

  assign frame.ready = !needs_slot || !job_valid || job_done;
  assign accept      = frame.valid && frame.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      chroma_column <= '0;
      chroma_row    <= '0;
      held_v        <= '0;
    end else if (accept) begin
      case (kind)
        K_IGNORE: ;
        K_PAST: begin
          byte_position <= frame_total;
          chroma_column <= col_eff;
          chroma_row    <= row_eff;
        end
        K_LUMA: begin
          byte_position <= pos_eff + POS_W'(1);
          chroma_column <= col_eff;
          chroma_row    <= row_eff;
        end
        K_CHROMA_V: begin
          byte_position <= pos_eff + POS_W'(1);
          chroma_column <= col_eff;
          chroma_row    <= row_eff;
          held_v        <= frame.frame_byte;
        end
        K_END: begin
          byte_position <= frame_total;
          chroma_column <= blk_col;
          chroma_row    <= blk_row;
        end
        K_BLOCK: begin
          byte_position <= pos_eff + POS_W'(1);
          if (col_inc >= half_w) begin
            chroma_column <= '0;
            chroma_row    <= blk_row + COORD_W'(1);
          end else begin
            chroma_column <= col_inc;
            chroma_row    <= blk_row;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      job_k     <= 2'd0;
    end else if (accept && (kind == K_BLOCK)) begin
      job_valid <= 1'b1;
      job_k     <= 2'd0;
    end else if (job_done) begin
      job_valid <= 1'b0;
      job_k     <= 2'd0;
    end else if (issue) begin
      job_k <= job_k + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (kind == K_BLOCK)) begin
      job_base       <= {row_prod, 1'b0} + IDX_W'({blk_col, 1'b0});
      job_last_block <= (blk_row == half_h - COORD_W'(1)) &&
                        (blk_col == half_w - COORD_W'(1));
      job_rv         <= C_RV * v_s;
      job_gv         <= C_GV * v_s + C_GU * u_s;
      job_bu         <= C_BU * u_s;
    end
  end

  // Luma memory: one write port for the plane, one read port for blocks.
  logic [IDX_W-1:0]  rd_index;
  logic              rd_in_range;
  logic [BYTE_W-1:0] rd_data;
  logic              luma_we;
  logic [BYTE_W-1:0] luma_mem [MAX_PIXELS];

  assign rd_index    = job_base + (job_k[1] ? IDX_W'(frame_width) : IDX_W'(0)) +
                       IDX_W'(job_k[0]);
  assign rd_in_range = rd_index < IDX_W'(frame_size);
  assign luma_we     = accept && (kind == K_LUMA);

  always_ff @(posedge clk) begin
    if (luma_we) begin
      luma_mem[pos_eff[ADDR_W-1:0]] <= frame.frame_byte;
    end
    if (issue) begin
      rd_data <= luma_mem[rd_index[ADDR_W-1:0]];
    end
  end

  // Read stage.
  logic                     s1_valid;
  logic [PIXEL_INDEX_W-1:0] s1_index;
  logic                     s1_in_range;
  logic                     s1_block_last;
  logic                     s1_frame_last;
  logic signed [CALC_W-1:0] s1_rv;
  logic signed [CALC_W-1:0] s1_gv;
  logic signed [CALC_W-1:0] s1_bu;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_index      <= rd_index[PIXEL_INDEX_W-1:0];
      s1_in_range   <= rd_in_range;
      s1_block_last <= &job_k;
      s1_frame_last <= (&job_k) && job_last_block;
      s1_rv         <= job_rv;
      s1_gv         <= job_gv;
      s1_bu         <= job_bu;
    end
  end

  // Multiply stage.
  logic [BYTE_W-1:0]        luma;
  logic [BYTE_W-1:0]        y_val;
  logic signed [CALC_W-1:0] y_s;
  logic signed [CALC_W-1:0] y_term;

  always_comb begin
    luma   = s1_in_range ? rd_data : '0;
    y_val  = (luma >= LUMA_OFFSET) ? luma - LUMA_OFFSET : '0;
    y_s    = CALC_W'(y_val);
    y_term = y_s * C_Y;
  end

  logic                     s2_valid;
  logic [PIXEL_INDEX_W-1:0] s2_index;
  logic                     s2_block_last;
  logic                     s2_frame_last;
  logic signed [CALC_W-1:0] s2_r;
  logic signed [CALC_W-1:0] s2_g;
  logic signed [CALC_W-1:0] s2_b;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_index      <= s1_index;
      s2_block_last <= s1_block_last;
      s2_frame_last <= s1_frame_last;
      s2_r          <= y_term + s1_rv;
      s2_g          <= y_term + s1_gv;
      s2_b          <= y_term + s1_bu;
    end
  end

  // Output register.
  logic [PIXEL_INDEX_W-1:0] out_index;
  logic [PIXEL_WORD_W-1:0]  out_word;
  logic                     out_block_last;
  logic                     out_frame_last;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_index      <= s2_index;
      out_word       <= {ALPHA, chan_byte(s2_b), chan_byte(s2_g), chan_byte(s2_r)};
      out_block_last <= s2_block_last;
      out_frame_last <= s2_frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= issue;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  assign pixel.valid       = out_valid;
  assign pixel.pixel_index = out_index;
  assign pixel.pixel_word  = out_word;
  assign pixel.block_last  = out_block_last;
  assign pixel.frame_last  = out_frame_last;

  `N2A_ASSERT_IMP(a_slot_free, clk, rst, accept && (kind == K_LUMA || kind == K_BLOCK), !job_valid || job_done)
  `N2A_ASSERT_NXT(a_job_loaded, clk, rst, accept && (kind == K_BLOCK), job_valid && (job_k == 2'd0))
  `N2A_ASSERT_IMP(a_last_pixel, clk, rst, pixel.valid && pixel.frame_last, pixel.block_last && pixel.pixel_index[0])

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NV21 to ARGB converter testbench
// Streams NV21 frames into the converter with random gaps and output stalls.
// A built-in model of the converter predicts each ARGB pixel and its flags,
// and every pixel item is checked against the oldest prediction. Covers the
// channel extremes, restarts, overruns, a disabled block, bad geometry, a
// 2048x2 and a 2x2048 geometry, and many small random frames.
// ----------------------------------------------------------------------------
module tb_top;
  import n2a_pkg::*;

  localparam int MAX_PIX      = 1048576;
  localparam int CYCLE_LIMIT  = 6000000;
  localparam int DRAIN_CYCLES = 16;
  localparam int REPORT_LIMIT = 10;
  localparam int RANDOM_ITEMS = 300;
  localparam int EDGE_ITEMS   = 16;

  typedef struct packed {
    logic [PIXEL_INDEX_W-1:0] index;
    logic [PIXEL_WORD_W-1:0]  word;
    logic                     blk_last;
    logic                     frm_last;
  } pixel_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  n2a_byte_if  frame_if ();
  n2a_pixel_if pixel_if ();

  nv21_to_argb_converter #(
    .MAX_PIXELS(MAX_PIX)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .frame     (frame_if),
    .pixel     (pixel_if)
  );

  pixel_t      pixel_q[$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          calm = 0;

  int unsigned geo_w = RESET_FRAME_WIDTH;
  int unsigned geo_h = RESET_FRAME_HEIGHT;
  bit          conv_en = 1;
  int unsigned byte_pos = 0;
  int unsigned blk_col = 0;
  int unsigned blk_row = 0;
  bit [7:0]    held_v = 8'd0;
  bit [7:0]    luma_mem [int unsigned];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int clamp_chan(int x);
    if (x < 0) return 0;
    if (x > 262143) return 262143;
    return x;
  endfunction

  function automatic logic [31:0] argb_word(bit [7:0] luma, int v, int u);
    int y;
    int r;
    int g;
    int b;
    y = int'(luma) - 16;
    if (y < 0) y = 0;
    r = clamp_chan(1192 * y + 1634 * v);
    g = clamp_chan(1192 * y - 833 * v - 400 * u);
    b = clamp_chan(1192 * y + 2066 * u);
    return {ALPHA, b[17:10], g[17:10], r[17:10]};
  endfunction

  function automatic void predict_byte(bit [7:0] b, bit sof);
    int unsigned fs;
    int unsigned total;
    int unsigned p;
    int unsigned idx;
    int unsigned base;
    int          v;
    int          u;
    bit          last_blk;
    bit [7:0]    luma;
    pixel_t      e;
    if (!conv_en) return;
    if (geo_w < 2 || geo_h < 2 || (geo_w % 2) != 0 || (geo_h % 2) != 0) return;
    fs = geo_w * geo_h;
    if (fs > MAX_PIX) return;
    total = fs + fs / 2;
    if (sof) begin
      byte_pos = 0;
      blk_col = 0;
      blk_row = 0;
    end
    if (byte_pos >= total) begin
      byte_pos = total;
      return;
    end
    p = byte_pos;
    byte_pos = p + 1;
    if (p < fs) begin
      luma_mem[p] = b;
      return;
    end
    if (((p - fs) % 2) == 0) begin
      held_v = b;
      return;
    end
    if (blk_col >= geo_w / 2) begin
      blk_col = 0;
      blk_row++;
    end
    if (blk_row >= geo_h / 2) begin
      byte_pos = total;
      return;
    end
    v = int'(held_v) - 128;
    u = int'(b) - 128;
    last_blk = (blk_row == geo_h / 2 - 1) && (blk_col == geo_w / 2 - 1);
    base = 2 * blk_row * geo_w + 2 * blk_col;
    for (int k = 0; k < 4; k++) begin
      idx = base + (((k & 2) != 0) ? geo_w : 0) + (k & 1);
      luma = (idx < fs && luma_mem.exists(idx)) ? luma_mem[idx] : 8'd0;
      e.index = idx[PIXEL_INDEX_W-1:0];
      e.word = argb_word(luma, v, u);
      e.blk_last = (k == 3);
      e.frm_last = (k == 3) && last_blk;
      pixel_q.push_back(e);
    end
    blk_col++;
    if (blk_col >= geo_w / 2) begin
      blk_col = 0;
      blk_row++;
    end
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%0t: %s", $realtime, what);
    end
  endtask

  always @(posedge clk) begin
    pixel_t exp_pix;
    if (!rst && pixel_if.valid && pixel_if.ready) begin
      if (pixel_q.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel: index %0d word %h",
                                  pixel_if.pixel_index, pixel_if.pixel_word));
      end else begin
        exp_pix = pixel_q.pop_front();
        if (pixel_if.pixel_index !== exp_pix.index || pixel_if.pixel_word !== exp_pix.word ||
            pixel_if.block_last !== exp_pix.blk_last ||
            pixel_if.frame_last !== exp_pix.frm_last) begin
          report_mismatch($sformatf(
            "pixel mismatch: expected %0d %h %0b %0b, got %0d %h %0b %0b",
            exp_pix.index, exp_pix.word, exp_pix.blk_last, exp_pix.frm_last,
            pixel_if.pixel_index, pixel_if.pixel_word, pixel_if.block_last,
            pixel_if.frame_last));
        end
      end
    end
  end

  initial begin
    int hold;
    hold = 0;
    pixel_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        pixel_if.ready = 1'b0;
        hold--;
      end else begin
        pixel_if.ready = 1'b1;
        hold = pick_gap();
      end
    end
  end

  task automatic send_byte(bit [7:0] b, bit sof);
    int gap;
    gap = pick_gap();
    if (gap > 0) repeat (gap) @(negedge clk);
    frame_if.valid = 1'b1;
    frame_if.frame_byte = b;
    frame_if.start_of_frame = sof;
    do @(posedge clk); while (!frame_if.ready);
    predict_byte(b, sof);
    @(negedge clk);
    frame_if.valid = 1'b0;
  endtask

  task automatic wait_results();
    while (pixel_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    wait_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(cfg_reg_t r, int unsigned d);
    cfg_write = 1'b1;
    cfg_index = r;
    cfg_data = d[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_write = 1'b0;
    case (r)
      CFG_FRAME_WIDTH: geo_w = d[CFG_DATA_W-1:0];
      CFG_FRAME_HEIGHT: geo_h = d[CFG_DATA_W-1:0];
      CFG_OUTPUT_ENABLE: conv_en = d[0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h);
    if (w != geo_w || h != geo_h) begin
      settle();
      write_cfg(CFG_FRAME_WIDTH, w);
      write_cfg(CFG_FRAME_HEIGHT, h);
    end
  endtask

  task automatic send_random_frame(int unsigned w, int unsigned h, int unsigned n, bit pause);
    set_geometry(w, h);
    for (int unsigned i = 0; i < n; i++) begin
      send_byte(rand_byte(), i == 0);
      if (pause && i == w * h + 1) wait_results();
    end
  endtask

  task automatic test_reset_defaults();
    send_byte(8'h5a, 1'b1);
    send_byte(8'ha5, 1'b0);
  endtask

  task automatic test_channel_extremes();
    bit [7:0] dark_bright[6];
    bit [7:0] bright_dark[6];
    dark_bright = '{8'd0, 8'd255, 8'd16, 8'd17, 8'd0, 8'd255};
    bright_dark = '{8'd255, 8'd235, 8'd15, 8'd128, 8'd255, 8'd0};
    set_geometry(2, 2);
    foreach (dark_bright[i]) send_byte(dark_bright[i], i == 0);
    foreach (bright_dark[i]) send_byte(bright_dark[i], i == 0);
  endtask

  task automatic test_restart_and_overrun();
    set_geometry(2, 2);
    send_byte(rand_byte(), 1'b1);
    send_byte(rand_byte(), 1'b0);
    send_random_frame(2, 2, 6, 1'b0);
    send_byte(rand_byte(), 1'b0);
    send_byte(rand_byte(), 1'b0);
  endtask

  task automatic test_disabled_input();
    settle();
    write_cfg(CFG_OUTPUT_ENABLE, 0);
    send_byte(rand_byte(), 1'b1);
    send_byte(rand_byte(), 1'b0);
    send_byte(rand_byte(), 1'b0);
    settle();
    write_cfg(CFG_OUTPUT_ENABLE, 1);
  endtask

  task automatic test_bad_geometry();
    settle();
    write_cfg(CFG_FRAME_WIDTH, 3);
    write_cfg(CFG_FRAME_HEIGHT, 2);
    send_byte(rand_byte(), 1'b1);
    settle();
    write_cfg(CFG_FRAME_WIDTH, 0);
    send_byte(rand_byte(), 1'b1);
    settle();
    write_cfg(CFG_FRAME_WIDTH, 2);
    write_cfg(CFG_FRAME_HEIGHT, 4095);
    send_byte(rand_byte(), 1'b1);
    settle();
    write_cfg(CFG_FRAME_WIDTH, 2048);
    write_cfg(CFG_FRAME_HEIGHT, 2048);
    send_byte(rand_byte(), 1'b1);
  endtask

  task automatic test_extreme_geometry();
    send_random_frame(2048, 2, EDGE_ITEMS, 1'b0);
    send_random_frame(2, 2048, EDGE_ITEMS, 1'b0);
  endtask

  task automatic test_random_frames();
    int unsigned w;
    int unsigned h;
    int unsigned n;
    int unsigned sent;
    bit          paused;
    int          choice;
    w = 4;
    h = 4;
    sent = 0;
    paused = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      choice = $urandom_range(0, 9);
      if (choice == 0) begin
        settle();
        write_cfg(CFG_OUTPUT_ENABLE, 0);
        repeat ($urandom_range(1, 6)) send_byte(rand_byte(), 1'($urandom_range(0, 1)));
        settle();
        write_cfg(CFG_OUTPUT_ENABLE, 1);
      end else begin
        if (paused && choice <= 4) begin
          w = 2 * $urandom_range(1, 6);
          h = 2 * $urandom_range(1, 4);
        end
        n = w * h * 3 / 2;
        if (paused && $urandom_range(0, 7) == 0) n = $urandom_range(1, n - 1);
        send_random_frame(w, h, n, !paused);
        paused = 1;
        sent += n;
        if (n == w * h * 3 / 2 && $urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 3)) send_byte(rand_byte(), 1'b0);
        end
      end
    end
    calm = 0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_FRAME_WIDTH;
    cfg_data = '0;
    frame_if.valid = 1'b0;
    frame_if.frame_byte = '0;
    frame_if.start_of_frame = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_channel_extremes();
    test_restart_and_overrun();
    test_disabled_input();
    test_bad_geometry();
    test_extreme_geometry();
    test_random_frames();

    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/n2a_pkg.sv
rtl/core/n2a_if.sv
rtl/core/nv21_to_argb_converter.sv
test/tb_top.sv
